>>> src/xtea_pkg.sv
// XTEA cipher package: shared constants, the key and stage types, and the
// shift-add part of the mix. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package xtea_pkg;

    localparam int WORD_W    = 32;
    localparam int KEY_WORDS = 4;
    localparam int KIDX_W    = 2;

    localparam logic [WORD_W-1:0] XTEA_DELTA = 32'h9E37_79B9;

    typedef enum logic
    {
        OP_ENCRYPT = 1'b0,
        OP_DECRYPT = 1'b1
    } op_t;

    typedef logic [KEY_WORDS-1:0][WORD_W-1:0] key_t;

    // one block moving down the round pipeline
    typedef struct packed
    {
        logic              valid;
        op_t               op;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
    } stage_t;

    function automatic logic [WORD_W-1:0] mix_shift(input logic [WORD_W-1:0] v);
        return ((v << 4) ^ (v >> 5)) + v;
    endfunction

endpackage

`default_nettype wire

>>> src/xtea_half_round.sv
// One registered XTEA half-round for either direction. The running sum and
// key slot are fixed per stage at elaboration. Depends on xtea_pkg.
`timescale 1ns / 1ps
`default_nettype none

module xtea_half_round #(
    parameter int CYCLE_COUNT = 32,
    parameter int STAGE_IDX   = 0
) (
    input  wire                logic clk,
    input  wire                logic rst_n,
    input  wire                logic en,
    input  wire xtea_pkg::key_t      key,
    input  wire xtea_pkg::stage_t    stage_in,
    output xtea_pkg::stage_t         stage_out
);
    import xtea_pkg::*;

    localparam int ROUND_IDX = STAGE_IDX / 2;
    localparam int IS_ODD    = STAGE_IDX % 2;
    localparam int ENC_MULT  = ROUND_IDX + IS_ODD;
    localparam int DEC_MULT  = CYCLE_COUNT - ROUND_IDX - IS_ODD;

    localparam logic [WORD_W-1:0] ENC_SUM = WORD_W'(XTEA_DELTA * ENC_MULT);
    localparam logic [WORD_W-1:0] DEC_SUM = WORD_W'(XTEA_DELTA * DEC_MULT);

    // first half-round takes sum[1:0], second takes sum[12:11]; decrypt mirrors
    localparam logic [KIDX_W-1:0] ENC_KIDX = (IS_ODD != 0) ? ENC_SUM[12:11] : ENC_SUM[1:0];
    localparam logic [KIDX_W-1:0] DEC_KIDX = (IS_ODD != 0) ? DEC_SUM[1:0] : DEC_SUM[12:11];
    localparam logic              ODD_BIT  = (IS_ODD != 0);

    logic              upd_a;
    logic [WORD_W-1:0] src_word;
    logic [WORD_W-1:0] dst_word;
    logic [WORD_W-1:0] sum_key;
    logic [WORD_W-1:0] mix;
    logic [WORD_W-1:0] new_word;
    stage_t            data_next;
    stage_t            data_reg;
    logic              valid_reg;

    always_comb
    begin
        upd_a    = ~(logic'(stage_in.op) ^ ODD_BIT);
        src_word = upd_a ? stage_in.b : stage_in.a;
        dst_word = upd_a ? stage_in.a : stage_in.b;
        if (stage_in.op == OP_DECRYPT)
        begin
            sum_key  = DEC_SUM + key[DEC_KIDX];
        end
        else
        begin
            sum_key  = ENC_SUM + key[ENC_KIDX];
        end
        mix      = mix_shift(src_word) ^ sum_key;
        new_word = (stage_in.op == OP_DECRYPT) ? dst_word - mix : dst_word + mix;

        data_next       = stage_in;
        data_next.valid = stage_in.valid;
        if (upd_a)
        begin
            data_next.a = new_word;
        end
        else
        begin
            data_next.b = new_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= stage_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    always_comb
    begin
        stage_out       = data_reg;
        stage_out.valid = valid_reg;
    end

endmodule

`default_nettype wire

>>> src/xtea_block_cipher.sv
// XTEA block cipher, 64-bit block, 128-bit key: one block accepted per clock
// while the spare output slot is empty. The round pipeline has one register
// stage per half-round and is followed by the output register. A two-entry
// output buffer (output register plus spare slot) catches one more result after
// the result side stalls, and input stops once the spare slot is full. Key words must
// be written while no block is in flight. Depends on xtea_pkg and xtea_half_round.
`timescale 1ns / 1ps
`default_nettype none

module xtea_block_cipher #(
    parameter int CYCLE_COUNT = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    // input blocks
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,   // [31:0] left_half, [63:32] right_half
    input  wire logic [0:0]  s_axis_tuser,   // [0] op (0 encrypt, 1 decrypt)
    // result blocks
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata    // [31:0] out_left, [63:32] out_right
);
    import xtea_pkg::*;

    localparam int STAGES = 2 * CYCLE_COUNT;

    typedef enum logic [1:0]
    {
        KEY_IDX_0 = 2'd0,
        KEY_IDX_1 = 2'd1,
        KEY_IDX_2 = 2'd2,
        KEY_IDX_3 = 2'd3
    } key_idx_t;

    key_t        key_reg;
    key_t        key_next;
    stage_t      pipe [0:STAGES];
    logic        en;
    logic        push;
    logic        take;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [63:0] out_data_reg;
    logic [63:0] out_data_next;
    logic        spare_valid_reg;
    logic        spare_valid_next;
    logic [63:0] spare_data_reg;
    logic [63:0] spare_data_next;

    // ---------------- key registers
    assign cfg_ready = 1'b1;

    always_comb
    begin
        key_next = key_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (key_idx_t'(cfg_index))
                KEY_IDX_0: key_next[0] = cfg_data;
                KEY_IDX_1: key_next[1] = cfg_data;
                KEY_IDX_2: key_next[2] = cfg_data;
                KEY_IDX_3: key_next[3] = cfg_data;
                default:   key_next    = key_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else
        begin
            key_reg <= key_next;
        end
    end

    // ---------------- round pipeline
    assign en            = ~spare_valid_reg;
    assign s_axis_tready = en;

    always_comb
    begin
        pipe[0].valid = s_axis_tvalid;
        pipe[0].op    = op_t'(s_axis_tuser[0]);
        pipe[0].a     = s_axis_tdata[31:0];
        pipe[0].b     = s_axis_tdata[63:32];
    end

    for (genvar i = 0; i < STAGES; i++)
    begin : g_round
        xtea_half_round #(
            .CYCLE_COUNT (CYCLE_COUNT),
            .STAGE_IDX   (i)
        ) u_half (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .key       (key_reg),
            .stage_in  (pipe[i]),
            .stage_out (pipe[i+1])
        );
    end

    // ---------------- output register with spare slot
    assign push = en & pipe[STAGES].valid;
    assign take = out_valid_reg & m_axis_tready;

    always_comb
    begin
        out_valid_next   = out_valid_reg;
        out_data_next    = out_data_reg;
        spare_valid_next = spare_valid_reg;
        spare_data_next  = spare_data_reg;
        if (spare_valid_reg)
        begin
            if (take)
            begin
                out_data_next    = spare_data_reg;
                spare_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || take)
            begin
                out_valid_next = 1'b1;
                out_data_next  = {pipe[STAGES].b, pipe[STAGES].a};
            end
            else
            begin
                spare_valid_next = 1'b1;
                spare_data_next  = {pipe[STAGES].b, pipe[STAGES].a};
            end
        end
        else if (take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            spare_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg   <= out_valid_next;
            spare_valid_reg <= spare_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg   <= out_data_next;
        spare_data_reg <= spare_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // ---------------- checks
    a_spare_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        spare_valid_reg |-> out_valid_reg)
        else $error("spare slot full while output register empty");

    a_spill_to_spare: assert property (@(posedge clk) disable iff (!rst_n)
        push && out_valid_reg && !m_axis_tready |=> spare_valid_reg)
        else $error("pipeline result not caught in spare slot");

    a_spare_drains: assert property (@(posedge clk) disable iff (!rst_n)
        spare_valid_reg && m_axis_tready |=> !spare_valid_reg)
        else $error("spare slot not drained after result taken");

    a_pipe_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(pipe[STAGES].valid))
        else $error("round pipeline moved while stalled");

endmodule

`default_nettype wire
